### rtl/mmp_pkg.sv
`default_nettype none

package mmp_pkg;

  // Default depth of the system exclusive store
  localparam int SYSEX_DEPTH_DEFAULT = 32;

  localparam int ENABLE_W = 9;

  // Result kinds
  localparam logic [3:0] KIND_NOTE_OFF   = 4'd0;
  localparam logic [3:0] KIND_NOTE_ON    = 4'd1;
  localparam logic [3:0] KIND_CC         = 4'd2;
  localparam logic [3:0] KIND_PROGRAM    = 4'd3;
  localparam logic [3:0] KIND_BEND       = 4'd4;
  localparam logic [3:0] KIND_SOUNDS_OFF = 4'd5;
  localparam logic [3:0] KIND_NOTES_OFF  = 4'd6;
  localparam logic [3:0] KIND_RESET      = 4'd7;
  localparam logic [3:0] KIND_SYSEX_BYTE = 4'd8;
  localparam logic [3:0] KIND_SYSEX_END  = 4'd9;

  // Enable mask bit positions
  localparam int EN_NOTE_OFF   = 0;
  localparam int EN_NOTE_ON    = 1;
  localparam int EN_CC         = 2;
  localparam int EN_PROGRAM    = 3;
  localparam int EN_BEND       = 4;
  localparam int EN_SOUNDS_OFF = 5;
  localparam int EN_NOTES_OFF  = 6;
  localparam int EN_SYSEX      = 7;
  localparam int EN_RESET      = 8;

  // Status nibbles
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_CC       = 4'hB;
  localparam logic [3:0] STAT_PROGRAM  = 4'hC;
  localparam logic [3:0] STAT_PRESSURE = 4'hD;
  localparam logic [3:0] STAT_BEND     = 4'hE;

  // Special bytes
  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_SENSE       = 8'hFE;
  localparam logic [7:0] BYTE_REALTIME    = 8'hF8;

  localparam logic [6:0] CC_ALL_SOUNDS_OFF = 7'd120;
  localparam logic [6:0] CC_ALL_NOTES_OFF  = 7'd123;

  // Reset strings, without F0/F7 framing
  localparam int GM_LEN = 4;
  localparam int XG_LEN = 7;
  localparam int GS_LEN = 9;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  value;
    logic [13:0] bend;
    logic [7:0]  sx_data;
    logic [5:0]  sx_len;
    logic        last;
  } event_t;

  function automatic logic [7:0] gm_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h7E;
      4'd1:    b = 8'h7F;
      4'd2:    b = 8'h09;
      4'd3:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] xg_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h43;
      4'd1:    b = 8'h10;
      4'd2:    b = 8'h4C;
      4'd5:    b = 8'h7E;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] gs_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h41;
      4'd1:    b = 8'h10;
      4'd2:    b = 8'h42;
      4'd3:    b = 8'h12;
      4'd4:    b = 8'h40;
      4'd6:    b = 8'h7F;
      4'd8:    b = 8'h41;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/midi_message_parser_top.sv
`default_nettype none

// MIDI message parser. Takes one received MIDI byte per request on the byte
// channel and emits decoded events on the event channel: note off/on (note on
// with velocity 0 is reported as note off), control change, all sounds off,
// all notes off, program change and 14-bit pitch bend, all with running
// status. Active sensing is dropped, and so are real-time bytes outside
// sysex. Other bytes between F0 and F7 go into an on-chip store of
// SYSEX_DEPTH bytes (wrapping to the start when full). At F7 the store
// is checked against the GM On, XG On and GS Reset strings; a match gives
// one reset event, otherwise the stored bytes stream out one per event
// followed by an end event with the length. event_enable masks each kind;
// write it only while the block is idle. An ordinary byte is taken
// whenever the event output register is free. After F7 is taken, a sysex
// dump holds byte_stall high until its end event is loaded, and longer
// while the event side stalls a pending event: each stored byte passes
// through a store read state and an output load state, and the end event
// through a state of its own. There is no clearing pass after reset; the
// store needs none. 'last' marks the final event caused by one input byte.
module midi_message_parser_top #(
  parameter int SYSEX_DEPTH = mmp_pkg::SYSEX_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         event_enable_write,
  input  wire logic [mmp_pkg::ENABLE_W-1:0] event_enable_data,
  // byte requests
  input  wire logic                         byte_valid,
  output logic                              byte_stall,
  input  wire logic [7:0]                   midi_byte,
  // event requests
  output logic                              event_valid,
  input  wire logic                         event_stall,
  output logic [3:0]                        event_kind,
  output logic [3:0]                        channel,
  output logic [6:0]                        key_or_controller,
  output logic [6:0]                        velocity_or_value,
  output logic [13:0]                       bend_amount,
  output logic [7:0]                        sysex_data,
  output logic [5:0]                        sysex_length,
  output logic                              last
);

  localparam int ADDR_W = $clog2(SYSEX_DEPTH);
  localparam int CNT_W  = $clog2(SYSEX_DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // taking bytes
  localparam logic [1:0] ST_READ = 2'd1;  // store read in flight
  localparam logic [1:0] ST_LOAD = 2'd2;  // read data into output register
  localparam logic [1:0] ST_END  = 2'd3;  // sysex end event

  logic [1:0] state, state_next;

  // Parser state
  logic [mmp_pkg::ENABLE_W-1:0] event_enable;
  logic                         in_sysex, in_sysex_next;
  logic [3:0]                   status_nibble, status_nibble_next;
  logic [3:0]                   status_channel, status_channel_next;
  logic                         awaiting_second, awaiting_second_next;
  logic [6:0]                   first_data, first_data_next;
  logic [CNT_W-1:0]             sysex_count, sysex_count_next;

  // Streaming state
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic [CNT_W-1:0] sx_len, sx_len_next;

  // Output register
  mmp_pkg::event_t ev, ev_next;
  logic            ev_load;

  logic byte_accept;
  logic slot_free;

  // Store ports
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [7:0]        rd_data;
  logic              reset_hit;

  // Decode
  logic            dec_go;
  logic [6:0]      dec_d1, dec_d2;
  logic            dec_fire;
  mmp_pkg::event_t dec_ev;

  logic store_full;

  assign slot_free   = !event_valid || !event_stall;
  assign byte_stall  = !((state == ST_IDLE) && slot_free);
  assign byte_accept = byte_valid && !byte_stall;

  // Wrap to the start once the store holds SYSEX_DEPTH bytes
  assign store_full = (sysex_count >= CNT_W'(SYSEX_DEPTH));
  assign wr_addr    = store_full ? '0 : sysex_count[ADDR_W-1:0];
  assign wr_en      = byte_accept && in_sysex &&
                      (midi_byte != mmp_pkg::BYTE_SYSEX_END) &&
                      (midi_byte != mmp_pkg::BYTE_SENSE);
  assign rd_en      = (state == ST_READ);

  // Second data byte completes a pair; C and D status take a single byte
  assign dec_go = byte_accept && !in_sysex && !midi_byte[7] &&
                  (awaiting_second ||
                   (status_nibble == mmp_pkg::STAT_PROGRAM) ||
                   (status_nibble == mmp_pkg::STAT_PRESSURE));
  assign dec_d1 = awaiting_second ? first_data : midi_byte[6:0];
  assign dec_d2 = awaiting_second ? midi_byte[6:0] : 7'd0;

  mmp_store #(
    .SYSEX_DEPTH(SYSEX_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (midi_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  mmp_reset_match #(
    .SYSEX_DEPTH(SYSEX_DEPTH)
  ) u_match (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (midi_byte),
    .count   (sysex_count),
    .hit     (reset_hit)
  );

  mmp_chan_decode u_decode (
    .enable (event_enable),
    .go     (dec_go),
    .nibble (status_nibble),
    .chan   (status_channel),
    .d1     (dec_d1),
    .d2     (dec_d2),
    .fire   (dec_fire),
    .ev     (dec_ev)
  );

  always_comb begin
    state_next           = state;
    in_sysex_next        = in_sysex;
    status_nibble_next   = status_nibble;
    status_channel_next  = status_channel;
    awaiting_second_next = awaiting_second;
    first_data_next      = first_data;
    sysex_count_next     = sysex_count;
    rd_idx_next          = rd_idx;
    sx_len_next          = sx_len;
    ev_next              = ev;
    ev_load              = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (byte_accept) begin
          if (in_sysex) begin
            if (midi_byte == mmp_pkg::BYTE_SYSEX_END) begin
              in_sysex_next    = 1'b0;
              sysex_count_next = '0;
              if (reset_hit) begin
                if (event_enable[mmp_pkg::EN_RESET]) begin
                  ev_load      = 1'b1;
                  ev_next      = '0;
                  ev_next.kind = mmp_pkg::KIND_RESET;
                  ev_next.last = 1'b1;
                end
              end else if (event_enable[mmp_pkg::EN_SYSEX]) begin
                rd_idx_next = '0;
                sx_len_next = sysex_count;
                state_next  = (sysex_count == '0) ? ST_END : ST_READ;
              end
            end else if (wr_en) begin
              sysex_count_next = store_full ? CNT_W'(1) : sysex_count + CNT_W'(1);
            end
          end else if ((midi_byte == mmp_pkg::BYTE_SENSE) ||
                       (midi_byte >= mmp_pkg::BYTE_REALTIME)) begin
            // real-time: dropped
          end else if (midi_byte == mmp_pkg::BYTE_SYSEX_START) begin
            in_sysex_next    = 1'b1;
            sysex_count_next = '0;
          end else if (midi_byte[7]) begin
            status_nibble_next   = midi_byte[7:4];
            status_channel_next  = midi_byte[3:0];
            awaiting_second_next = 1'b0;
          end else if (awaiting_second) begin
            awaiting_second_next = 1'b0;
          end else if ((status_nibble < mmp_pkg::STAT_PROGRAM) ||
                       (status_nibble == mmp_pkg::STAT_BEND)) begin
            awaiting_second_next = 1'b1;
            first_data_next      = midi_byte[6:0];
          end else if (status_nibble < mmp_pkg::STAT_BEND) begin
            first_data_next = midi_byte[6:0];
          end
          if (dec_fire) begin
            ev_load = 1'b1;
            ev_next = dec_ev;
          end
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          ev_load         = 1'b1;
          ev_next         = '0;
          ev_next.kind    = mmp_pkg::KIND_SYSEX_BYTE;
          ev_next.sx_data = rd_data;
          rd_idx_next     = rd_idx + CNT_W'(1);
          state_next      = (rd_idx + CNT_W'(1) == sx_len) ? ST_END : ST_READ;
        end
      end
      ST_END: begin
        if (slot_free) begin
          ev_load        = 1'b1;
          ev_next        = '0;
          ev_next.kind   = mmp_pkg::KIND_SYSEX_END;
          ev_next.sx_len = 6'(sx_len);
          ev_next.last   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      event_enable    <= '0;
      in_sysex        <= 1'b0;
      status_nibble   <= '0;
      status_channel  <= '0;
      awaiting_second <= 1'b0;
      first_data      <= '0;
      sysex_count     <= '0;
      rd_idx          <= '0;
      sx_len          <= '0;
      event_valid     <= 1'b0;
    end else begin
      state           <= state_next;
      in_sysex        <= in_sysex_next;
      status_nibble   <= status_nibble_next;
      status_channel  <= status_channel_next;
      awaiting_second <= awaiting_second_next;
      first_data      <= first_data_next;
      sysex_count     <= sysex_count_next;
      rd_idx          <= rd_idx_next;
      sx_len          <= sx_len_next;
      if (event_enable_write) begin
        event_enable <= event_enable_data;
      end
      if (ev_load) begin
        event_valid <= 1'b1;
      end else if (!event_stall) begin
        event_valid <= 1'b0;
      end
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk) begin
    if (ev_load) begin
      ev <= ev_next;
    end
  end

  assign event_kind        = ev.kind;
  assign channel           = ev.channel;
  assign key_or_controller = ev.key;
  assign velocity_or_value = ev.value;
  assign bend_amount       = ev.bend;
  assign sysex_data        = ev.sx_data;
  assign sysex_length      = ev.sx_len;
  assign last              = ev.last;

  // Store is never written while a dump is being read out
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("store read and write in the same cycle");

  // A pending event is never overwritten
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_stall) |-> !ev_load)
    else $error("output register loaded while stalled");

  // Input held off for the whole dump
  a_stall_in_dump: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> byte_stall)
    else $error("byte taken during sysex dump");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sysex_count <= CNT_W'(SYSEX_DEPTH))
    else $error("sysex count beyond store depth");

  // Every read is followed by the load state
  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_LOAD))
    else $error("store read data not consumed");

endmodule

`default_nettype wire

### rtl/mmp_store.sv
`default_nettype none

// Sysex byte store: one write port, one registered read port.
module mmp_store #(
  parameter int SYSEX_DEPTH = mmp_pkg::SYSEX_DEPTH_DEFAULT,
  localparam int ADDR_W = $clog2(SYSEX_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [SYSEX_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/mmp_reset_match.sv
`default_nettype none

// Tracks, as bytes are written, whether the store still holds a prefix of
// each reset string. A write at position 0 restarts the tracking.
module mmp_reset_match #(
  parameter int SYSEX_DEPTH = mmp_pkg::SYSEX_DEPTH_DEFAULT,
  localparam int ADDR_W = $clog2(SYSEX_DEPTH),
  localparam int CNT_W  = $clog2(SYSEX_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic [CNT_W-1:0]  count,
  output logic                   hit
);

  logic gm_ok, xg_ok, gs_ok;
  logic gm_ok_next, xg_ok_next, gs_ok_next;
  logic first;
  logic [3:0] idx;

  assign first = (wr_addr == '0);
  assign idx   = wr_addr[3:0];

  always_comb begin
    gm_ok_next = (first || gm_ok) &&
                 ((wr_addr >= ADDR_W'(mmp_pkg::GM_LEN)) || (wr_data == mmp_pkg::gm_byte(idx)));
    xg_ok_next = (first || xg_ok) &&
                 ((wr_addr >= ADDR_W'(mmp_pkg::XG_LEN)) || (wr_data == mmp_pkg::xg_byte(idx)));
    gs_ok_next = (first || gs_ok) &&
                 ((wr_addr >= ADDR_W'(mmp_pkg::GS_LEN)) || (wr_data == mmp_pkg::gs_byte(idx)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gm_ok <= 1'b0;
      xg_ok <= 1'b0;
      gs_ok <= 1'b0;
    end else if (wr_en) begin
      gm_ok <= gm_ok_next;
      xg_ok <= xg_ok_next;
      gs_ok <= gs_ok_next;
    end
  end

  assign hit = ((count == CNT_W'(mmp_pkg::GM_LEN)) && gm_ok) ||
               ((count == CNT_W'(mmp_pkg::XG_LEN)) && xg_ok) ||
               ((count == CNT_W'(mmp_pkg::GS_LEN)) && gs_ok);

endmodule

`default_nettype wire

### rtl/mmp_chan_decode.sv
`default_nettype none

// Channel message decode for a completed set of data bytes.
module mmp_chan_decode (
  input  wire logic [mmp_pkg::ENABLE_W-1:0] enable,
  input  wire logic                         go,
  input  wire logic [3:0]                   nibble,
  input  wire logic [3:0]                   chan,
  input  wire logic [6:0]                   d1,
  input  wire logic [6:0]                   d2,
  output logic                              fire,
  output mmp_pkg::event_t                   ev
);

  always_comb begin
    fire       = 1'b0;
    ev         = '0;
    ev.channel = chan;
    ev.last    = 1'b1;
    unique case (nibble)
      mmp_pkg::STAT_NOTE_OFF: begin
        fire     = enable[mmp_pkg::EN_NOTE_OFF];
        ev.kind  = mmp_pkg::KIND_NOTE_OFF;
        ev.key   = d1;
        ev.value = d2;
      end
      mmp_pkg::STAT_NOTE_ON: begin
        ev.key = d1;
        if (d2 == '0) begin
          fire    = enable[mmp_pkg::EN_NOTE_OFF];
          ev.kind = mmp_pkg::KIND_NOTE_OFF;
        end else begin
          fire     = enable[mmp_pkg::EN_NOTE_ON];
          ev.kind  = mmp_pkg::KIND_NOTE_ON;
          ev.value = d2;
        end
      end
      mmp_pkg::STAT_CC: begin
        ev.key = d1;
        if (d1 == mmp_pkg::CC_ALL_SOUNDS_OFF) begin
          fire    = enable[mmp_pkg::EN_SOUNDS_OFF];
          ev.kind = mmp_pkg::KIND_SOUNDS_OFF;
        end else if (d1 == mmp_pkg::CC_ALL_NOTES_OFF) begin
          fire    = enable[mmp_pkg::EN_NOTES_OFF];
          ev.kind = mmp_pkg::KIND_NOTES_OFF;
        end else begin
          fire     = enable[mmp_pkg::EN_CC];
          ev.kind  = mmp_pkg::KIND_CC;
          ev.value = d2;
        end
      end
      mmp_pkg::STAT_PROGRAM: begin
        fire    = enable[mmp_pkg::EN_PROGRAM];
        ev.kind = mmp_pkg::KIND_PROGRAM;
        ev.key  = d1;
      end
      mmp_pkg::STAT_BEND: begin
        fire    = enable[mmp_pkg::EN_BEND];
        ev.kind = mmp_pkg::KIND_BEND;
        ev.bend = {d2, d1};
      end
      default: begin
        fire = 1'b0;
      end
    endcase
    fire = fire && go;
  end

endmodule

`default_nettype wire

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DUMP_DEPTH = mmp_pkg::SYSEX_DEPTH_DEFAULT;
  // Room for the worst sysex dump to hold the byte side; leave margin.
  localparam int DRAIN_CYCLES = 4 * DUMP_DEPTH + 40;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 70;
  // Far beyond the slowest legal run.
  localparam longint WATCHDOG_NS = 64'd14_400_000;

  // Polyphonic pressure: decoded as a pair but never reported.
  localparam logic [3:0] STAT_POLY_PRESSURE = 4'hA;

  // Reset strings without framing, first byte in the top used bits.
  localparam logic [71:0] GM_ON_STR = 72'h7E7F0901;
  localparam logic [71:0] XG_ON_STR = 72'h43104C00007E00;
  localparam logic [71:0] GS_RST_STR = 72'h4110421240007F0041;

  localparam logic [mmp_pkg::ENABLE_W-1:0] DUMPS_ONLY =
    mmp_pkg::ENABLE_W'((1 << mmp_pkg::EN_SYSEX) | (1 << mmp_pkg::EN_RESET) |
                       (1 << mmp_pkg::EN_BEND));

  // Warm-up: note on/off, all sounds/notes off, program, bend and reset
  // events, field extremes, running status, ignored bytes and one GM System On dump.
  localparam logic [7:0] WARMUP_BYTES [26] = '{
    {mmp_pkg::STAT_NOTE_ON, 4'h0}, 8'h3C, 8'h64,
    8'h00, 8'h00,
    {mmp_pkg::STAT_NOTE_OFF, 4'hF}, 8'h7F, 8'h7F,
    {mmp_pkg::STAT_CC, 4'h5}, {1'b0, mmp_pkg::CC_ALL_SOUNDS_OFF}, 8'h00,
    {1'b0, mmp_pkg::CC_ALL_NOTES_OFF}, 8'h7F,
    {mmp_pkg::STAT_PROGRAM, 4'hA}, 8'h7F,
    {mmp_pkg::STAT_BEND, 4'h3}, 8'h7F, 8'h7F,
    mmp_pkg::BYTE_SENSE, mmp_pkg::BYTE_REALTIME,
    mmp_pkg::BYTE_SYSEX_START, 8'h7E, 8'h7F, 8'h09, 8'h01, mmp_pkg::BYTE_SYSEX_END
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  // Tracks the parser state from the accepted bytes and holds the events
  // that must come out, oldest first.
  class midi_event_tracker;
    mmp_pkg::event_t expected_events[$];
    mmp_pkg::event_t fresh[$];
    logic [mmp_pkg::ENABLE_W-1:0] enable_mask;
    bit in_dump;
    logic [3:0] run_status;
    logic [3:0] run_channel;
    bit have_first;
    logic [6:0] held_first;
    logic [7:0] dump_bytes [DUMP_DEPTH];
    int dump_len;
    int failures;

    function new();
      enable_mask = '0;
      in_dump = 1'b0;
      run_status = '0;
      run_channel = '0;
      have_first = 1'b0;
      held_first = '0;
      dump_len = 0;
      failures = 0;
    endfunction

    function void queue_event(int en_bit, logic [3:0] kind, logic [3:0] ch,
                              logic [6:0] key, logic [6:0] val, logic [13:0] bend,
                              logic [7:0] sx, logic [5:0] len);
      mmp_pkg::event_t e;
      if (!enable_mask[en_bit]) return;
      e.kind = kind;
      e.channel = ch;
      e.key = key;
      e.value = val;
      e.bend = bend;
      e.sx_data = sx;
      e.sx_len = len;
      e.last = 1'b0;
      fresh.insert(fresh.size(), e);
    endfunction

    function void decode_pair(logic [6:0] d1, logic [6:0] d2);
      case (run_status)
        mmp_pkg::STAT_NOTE_OFF:
          queue_event(mmp_pkg::EN_NOTE_OFF, mmp_pkg::KIND_NOTE_OFF, run_channel, d1, d2,
                      '0, '0, '0);
        mmp_pkg::STAT_NOTE_ON: begin
          if (d2 == 0)
            queue_event(mmp_pkg::EN_NOTE_OFF, mmp_pkg::KIND_NOTE_OFF, run_channel, d1,
                        '0, '0, '0, '0);
          else
            queue_event(mmp_pkg::EN_NOTE_ON, mmp_pkg::KIND_NOTE_ON, run_channel, d1, d2,
                        '0, '0, '0);
        end
        mmp_pkg::STAT_CC: begin
          if (d1 == mmp_pkg::CC_ALL_SOUNDS_OFF)
            queue_event(mmp_pkg::EN_SOUNDS_OFF, mmp_pkg::KIND_SOUNDS_OFF, run_channel,
                        mmp_pkg::CC_ALL_SOUNDS_OFF, '0, '0, '0, '0);
          else if (d1 == mmp_pkg::CC_ALL_NOTES_OFF)
            queue_event(mmp_pkg::EN_NOTES_OFF, mmp_pkg::KIND_NOTES_OFF, run_channel,
                        mmp_pkg::CC_ALL_NOTES_OFF, '0, '0, '0, '0);
          else
            queue_event(mmp_pkg::EN_CC, mmp_pkg::KIND_CC, run_channel, d1, d2,
                        '0, '0, '0);
        end
        mmp_pkg::STAT_PROGRAM:
          queue_event(mmp_pkg::EN_PROGRAM, mmp_pkg::KIND_PROGRAM, run_channel, d1, '0,
                      '0, '0, '0);
        mmp_pkg::STAT_BEND:
          queue_event(mmp_pkg::EN_BEND, mmp_pkg::KIND_BEND, run_channel, '0, '0,
                      {d2, d1}, '0, '0);
        default: begin
        end
      endcase
    endfunction

    function bit dump_equals(logic [71:0] str, int len);
      int i;
      if (dump_len != len) return 1'b0;
      for (i = 0; i < len; i++)
        if (dump_bytes[i] != str[8*(len-1-i) +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void close_dump();
      int i;
      if (dump_equals(GM_ON_STR, mmp_pkg::GM_LEN) ||
          dump_equals(XG_ON_STR, mmp_pkg::XG_LEN) ||
          dump_equals(GS_RST_STR, mmp_pkg::GS_LEN)) begin
        queue_event(mmp_pkg::EN_RESET, mmp_pkg::KIND_RESET, '0, '0, '0, '0, '0, '0);
      end else if (enable_mask[mmp_pkg::EN_SYSEX]) begin
        for (i = 0; i < dump_len; i++)
          queue_event(mmp_pkg::EN_SYSEX, mmp_pkg::KIND_SYSEX_BYTE, '0, '0, '0, '0,
                      dump_bytes[i], '0);
        queue_event(mmp_pkg::EN_SYSEX, mmp_pkg::KIND_SYSEX_END, '0, '0, '0, '0, '0,
                    6'(dump_len));
      end
      dump_len = 0;
    endfunction

    // Called once per accepted byte request.
    function void take_byte(logic [7:0] b);
      mmp_pkg::event_t e;
      int i;
      fresh.delete();
      if (in_dump) begin
        if (b == mmp_pkg::BYTE_SYSEX_END) begin
          in_dump = 1'b0;
          close_dump();
        end else if (b != mmp_pkg::BYTE_SENSE) begin
          if (dump_len >= DUMP_DEPTH) dump_len = 0;
          dump_bytes[dump_len] = b;
          dump_len++;
        end
      end else if (b == mmp_pkg::BYTE_SENSE || b >= mmp_pkg::BYTE_REALTIME) begin
        // real-time, dropped
      end else if (b == mmp_pkg::BYTE_SYSEX_START) begin
        in_dump = 1'b1;
        dump_len = 0;
      end else if (b[7]) begin
        run_status = b[7:4];
        run_channel = b[3:0];
        have_first = 1'b0;
      end else if (have_first) begin
        have_first = 1'b0;
        decode_pair(held_first, b[6:0]);
      end else if (run_status < mmp_pkg::STAT_PROGRAM || run_status == mmp_pkg::STAT_BEND) begin
        have_first = 1'b1;
        held_first = b[6:0];
      end else if (run_status < mmp_pkg::STAT_BEND) begin
        held_first = b[6:0];
        decode_pair(b[6:0], 7'd0);
      end
      for (i = 0; i < fresh.size(); i++) begin
        e = fresh[i];
        e.last = (i == fresh.size() - 1);
        expected_events.insert(expected_events.size(), e);
      end
    endfunction

    function string show(mmp_pkg::event_t e);
      return $sformatf("kind=%0d ch=%0d key=%0d val=%0d bend=%0d sx=%02h len=%0d last=%0d",
                       e.kind, e.channel, e.key, e.value, e.bend, e.sx_data, e.sx_len,
                       e.last);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    // Called once per accepted event request.
    function void check_event(mmp_pkg::event_t got);
      mmp_pkg::event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event: %s", show(got)));
      end else begin
        want = expected_events.pop_front();
        if (got !== want)
          report($sformatf("event differs: expected %s, got %s", show(want), show(got)));
      end
    endfunction

    function void flush_leftovers();
      while (expected_events.size() != 0)
        report($sformatf("event never seen: %s", show(expected_events.pop_front())));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic event_enable_write = 1'b0;
  logic [mmp_pkg::ENABLE_W-1:0] event_enable_data = '0;
  logic byte_valid = 1'b0;
  logic byte_stall;
  logic [7:0] midi_byte = '0;
  logic event_valid;
  logic event_stall = 1'b0;
  logic [3:0] event_kind;
  logic [3:0] channel;
  logic [6:0] key_or_controller;
  logic [6:0] velocity_or_value;
  logic [13:0] bend_amount;
  logic [7:0] sysex_data;
  logic [5:0] sysex_length;
  logic last;

  midi_event_tracker tracker = new();

  int burst_left = 0;
  int items_sent = 0;
  stall_style_e stall_style = STALL_NONE;
  int stall_span = 0;

  midi_message_parser_top dut (
    .clk(clk),
    .rst(rst),
    .event_enable_write(event_enable_write),
    .event_enable_data(event_enable_data),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .midi_byte(midi_byte),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .event_kind(event_kind),
    .channel(channel),
    .key_or_controller(key_or_controller),
    .velocity_or_value(velocity_or_value),
    .bend_amount(bend_amount),
    .sysex_data(sysex_data),
    .sysex_length(sysex_length),
    .last(last)
  );

  always #6 clk = ~clk;

  // Both channels are observed in one process so that a byte request is
  // always fed to the tracker before any event checked at the same edge.
  always @(posedge clk) begin : watch_ports
    mmp_pkg::event_t seen;
    if (!rst) begin
      if (byte_valid && !byte_stall) tracker.take_byte(midi_byte);
      if (event_valid && !event_stall) begin
        seen.kind = event_kind;
        seen.channel = channel;
        seen.key = key_or_controller;
        seen.value = velocity_or_value;
        seen.bend = bend_amount;
        seen.sx_data = sysex_data;
        seen.sx_len = sysex_length;
        seen.last = last;
        tracker.check_event(seen);
      end
    end
  end

  // Receiver back-pressure: each span picks a style; the periodic style
  // gives gaps that line up with the dump streaming in changing phases.
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_style <= stall_style_e'($urandom_range(0, 3));
      stall_span <= $urandom_range(40, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      STALL_NONE: event_stall <= 1'b0;
      STALL_LIGHT: event_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: event_stall <= ($urandom_range(0, 3) != 0);
      default: event_stall <= ((stall_span % 16) < 6);
    endcase
  end

  // Runs at a falling edge and returns at a falling edge. Bytes go out in
  // bursts; valid only drops between bursts.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    byte_valid <= 1'b1;
    midi_byte <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off until every expected event is out, then let a full dump time pass.
  task automatic wait_idle();
    byte_valid <= 1'b0;
    burst_left = 0;
    while (tracker.expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_enable(input logic [mmp_pkg::ENABLE_W-1:0] mask);
    event_enable_write <= 1'b1;
    event_enable_data <= mask;
    tracker.enable_mask = mask;
    @(negedge clk);
    event_enable_write <= 1'b0;
  endtask

  function automatic logic [6:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  // Mostly plain data; some status bytes (stored as data) and active sensing.
  function automatic logic [7:0] pick_dump_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      8: b = mmp_pkg::BYTE_SENSE;
      9: begin
        b = 8'($urandom_range(128, 255));
        if (b == mmp_pkg::BYTE_SYSEX_END) b = mmp_pkg::BYTE_SYSEX_START;
      end
      default: b = 8'($urandom_range(0, 127));
    endcase
    return b;
  endfunction

  task automatic send_voice();
    logic [3:0] nib;
    logic [6:0] d1;
    logic [6:0] d2;
    int reps;
    int i;
    case ($urandom_range(0, 9))
      0: nib = mmp_pkg::STAT_NOTE_OFF;
      1, 2: nib = mmp_pkg::STAT_NOTE_ON;
      3, 4: nib = mmp_pkg::STAT_CC;
      5: nib = mmp_pkg::STAT_PROGRAM;
      6, 7: nib = mmp_pkg::STAT_BEND;
      8: nib = mmp_pkg::STAT_PRESSURE;
      default: nib = STAT_POLY_PRESSURE;
    endcase
    // Sometimes lean on running status from whatever came before.
    if ($urandom_range(0, 3) != 0) send_byte({nib, 4'($urandom_range(0, 15))});
    reps = $urandom_range(1, 3);
    for (i = 0; i < reps; i++) begin
      d1 = pick_data();
      if (nib == mmp_pkg::STAT_CC && $urandom_range(0, 3) == 0)
        d1 = $urandom_range(0, 1) ? mmp_pkg::CC_ALL_SOUNDS_OFF : mmp_pkg::CC_ALL_NOTES_OFF;
      send_byte({1'b0, d1});
      if (nib < mmp_pkg::STAT_PROGRAM || nib == mmp_pkg::STAT_BEND) begin
        d2 = pick_data();
        if (nib == mmp_pkg::STAT_NOTE_ON && $urandom_range(0, 3) == 0) d2 = 7'd0;
        send_byte({1'b0, d2});
      end
    end
  endtask

  // One of the three reset strings, possibly with one byte spoiled and
  // possibly with active sensing mixed in.
  task automatic send_reset_string(input bit spoil);
    logic [71:0] str;
    logic [7:0] b;
    int len;
    int bad_pos;
    int i;
    case ($urandom_range(0, 2))
      0: begin
        str = GM_ON_STR;
        len = mmp_pkg::GM_LEN;
      end
      1: begin
        str = XG_ON_STR;
        len = mmp_pkg::XG_LEN;
      end
      default: begin
        str = GS_RST_STR;
        len = mmp_pkg::GS_LEN;
      end
    endcase
    bad_pos = spoil ? $urandom_range(0, len - 1) : -1;
    for (i = 0; i < len; i++) begin
      b = str[8*(len-1-i) +: 8];
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 127));
      send_byte(b);
      if ($urandom_range(0, 7) == 0) send_byte(mmp_pkg::BYTE_SENSE);
    end
  endtask

  task automatic send_dump();
    int n;
    int i;
    int pick;
    send_byte(mmp_pkg::BYTE_SYSEX_START);
    pick = $urandom_range(0, 19);
    if (pick < 6) begin
      send_reset_string($urandom_range(0, 2) == 0);
    end else if (pick < 16) begin
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) send_byte(pick_dump_byte());
    end else if (pick < 18) begin
      // around a full store and past it, so the store wraps
      n = $urandom_range(DUMP_DEPTH - 3, DUMP_DEPTH + 8);
      for (i = 0; i < n; i++) send_byte(pick_dump_byte());
    end else begin
      // full store, then a reset string that lands at the wrapped start
      for (i = 0; i < DUMP_DEPTH; i++) send_byte(8'($urandom_range(0, 127)));
      send_reset_string(1'b0);
    end
    send_byte(mmp_pkg::BYTE_SYSEX_END);
  endtask

  // System common (F1..F7 leave no usable status) or real-time, then data.
  task automatic send_system();
    int n;
    int i;
    send_byte(8'($urandom_range(8'hF1, 8'hFF)));
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) send_byte({1'b0, pick_data()});
  endtask

  task automatic send_noise();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_message();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) send_voice();
    else if (pick < 70) send_dump();
    else if (pick < 82) send_system();
    else send_noise();
  endtask

  initial begin
    #WATCHDOG_NS;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int phase_end;
    int i;
    logic [mmp_pkg::ENABLE_W-1:0] mask;

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    load_enable('1);
    for (i = 0; i < $size(WARMUP_BYTES); i++) send_byte(WARMUP_BYTES[i]);
    wait_idle();

    // Each phase runs under its own enable mask, written only when idle.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0, 5: mask = '1;
        2: mask = '0;
        4: mask = DUMPS_ONLY;
        default: mask = mmp_pkg::ENABLE_W'($urandom_range(0, 511));
      endcase
      load_enable(mask);
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) send_random_message();
      wait_idle();
    end

    tracker.flush_leftovers();
    if (tracker.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
